// ===== rtl/core/frustum_plane_cull_test_core_macros.svh =====
// Assertion macros shared by the frustum cull core.
`ifndef FRUSTUM_PLANE_CULL_TEST_CORE_MACROS_SVH
`define FRUSTUM_PLANE_CULL_TEST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define FPCT_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> post) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define FPCT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/core/fpct_pkg.sv =====
// Package: types, sizes and operation codes of the frustum cull core.
`timescale 1ns / 1ps

package fpct_pkg;

	localparam int NUM_PLANES = 6;
	localparam int FRAC_BITS  = 16;

	localparam int WORD_W = 32;
	localparam int OP_W   = 2;
	localparam int PIDX_W = 3;
	localparam int PROD_W = 2 * WORD_W;
	localparam int OFS_W  = WORD_W + 1;
	// three products plus the shifted offset never leave this range
	localparam int ACC_W  = 2 * WORD_W + 2;

	// cycles from the accepting edge to the edge that takes the result
	localparam int RES_LAT = NUM_PLANES + 1;

	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_POINT  = 2'd1;
	localparam logic [OP_W-1:0] OP_SPHERE = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef logic signed [WORD_W-1:0] word_t;

	// item as it walks down the cell chain
	typedef struct packed {
		logic              vld;
		logic [OP_W-1:0]   op;
		logic [PIDX_W-1:0] idx;
		word_t             x;
		word_t             y;
		word_t             z;
		word_t             w;
	} tok_t;

	// one stored plane
	typedef struct packed {
		word_t nx;
		word_t ny;
		word_t nz;
		word_t d;
	} plane_t;

	// running verdict handed from cell to cell
	typedef struct packed {
		logic vld;
		logic in_all;
	} verdict_t;

endpackage

// ===== rtl/core/fpct_cell.sv =====
// One chain cell: holds one plane, multiplies, then sums and checks the sign.
`timescale 1ns / 1ps

module fpct_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [fpct_pkg::PIDX_W-1:0] slot,
	input  fpct_pkg::tok_t              tok_in,
	output fpct_pkg::tok_t              tok_out,
	input  logic                        inside_in,
	output fpct_pkg::verdict_t          vdt_out
);

	fpct_pkg::plane_t plane_q;

	logic                               test_s1;
	logic                               sphere_s1;
	logic signed [fpct_pkg::PROD_W-1:0] px_s1;
	logic signed [fpct_pkg::PROD_W-1:0] py_s1;
	logic signed [fpct_pkg::PROD_W-1:0] pz_s1;
	logic signed [fpct_pkg::OFS_W-1:0]  offs_s1;

	logic                               is_load;
	logic                               is_test;
	logic                               is_sphere;
	logic signed [fpct_pkg::OFS_W-1:0]  offs;
	logic signed [fpct_pkg::ACC_W-1:0]  acc;
	logic                               ok;

	// decode the item in front of this cell
	always_comb begin
		is_load   = tok_in.vld && (tok_in.op == fpct_pkg::OP_LOAD) && (tok_in.idx == slot);
		is_sphere = tok_in.op == fpct_pkg::OP_SPHERE;
		is_test   = tok_in.vld && ((tok_in.op == fpct_pkg::OP_POINT) || is_sphere);
		// sphere adds its radius to the plane offset
		offs = fpct_pkg::OFS_W'(plane_q.d) +
			(is_sphere ? fpct_pkg::OFS_W'(tok_in.w) : fpct_pkg::OFS_W'(0));
	end

	// plane storage, loaded when a load item for this slot passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (is_load) begin
			plane_q <= '{nx: tok_in.x, ny: tok_in.y, nz: tok_in.z, d: tok_in.w};
		end
	end

	// control: item moves on, test flags follow into the sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out   <= '0;
			test_s1   <= 1'b0;
			sphere_s1 <= 1'b0;
			vdt_out   <= '0;
		end else begin
			tok_out      <= tok_in;
			test_s1      <= is_test;
			sphere_s1    <= is_sphere;
			vdt_out.vld    <= test_s1;
			vdt_out.in_all <= inside_in & ok;
		end
	end

	// products, one multiplier per normal component
	always_ff @(posedge clk) begin
		px_s1   <= fpct_pkg::PROD_W'(plane_q.nx) * fpct_pkg::PROD_W'(tok_in.x);
		py_s1   <= fpct_pkg::PROD_W'(plane_q.ny) * fpct_pkg::PROD_W'(tok_in.y);
		pz_s1   <= fpct_pkg::PROD_W'(plane_q.nz) * fpct_pkg::PROD_W'(tok_in.z);
		offs_s1 <= offs;
	end

	// exact signed distance and inside check
	always_comb begin
		acc = fpct_pkg::ACC_W'(px_s1) + fpct_pkg::ACC_W'(py_s1) + fpct_pkg::ACC_W'(pz_s1) +
			(fpct_pkg::ACC_W'(offs_s1) <<< fpct_pkg::FRAC_BITS);
		if (sphere_s1) begin
			ok = !acc[fpct_pkg::ACC_W-1] && (acc != '0);
		end else begin
			ok = !acc[fpct_pkg::ACC_W-1];
		end
	end

endmodule

// ===== rtl/core/frustum_plane_cull_test_core.sv =====
// Top level: six-plane frustum cull core built as a chain of plane cells.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  command  | start && !busy      | operation, plane_index, vec_x/y/z/w
//  result   | done (one cycle)    | inside_res
//
// An item enters cell 0 at its accepting edge and moves one cell per cycle.
// A test's result is registered by cell 0's product registers at the accepting
// edge, then each later cell's product registers, then the last cell's verdict
// register, which drives done; loads and operation code 3 give no result.
// The chain takes a new item every cycle; busy stays low and loads are ordered
// with tests because each cell writes its plane only when the load reaches it.
// Reset clears all planes to zero; until planes load, point tests report inside
// and sphere tests only with a positive radius; the receiver cannot stall.
`timescale 1ns / 1ps
`include "frustum_plane_cull_test_core_macros.svh"

module frustum_plane_cull_test_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [fpct_pkg::OP_W-1:0]   operation,
	input  logic [fpct_pkg::PIDX_W-1:0] plane_index,
	input  logic signed [fpct_pkg::WORD_W-1:0] vec_x,
	input  logic signed [fpct_pkg::WORD_W-1:0] vec_y,
	input  logic signed [fpct_pkg::WORD_W-1:0] vec_z,
	input  logic signed [fpct_pkg::WORD_W-1:0] vec_w,
	output logic                        done,
	output logic                        inside_res
);

	fpct_pkg::tok_t     tok_c [fpct_pkg::NUM_PLANES+1];
	fpct_pkg::verdict_t vdt_c [fpct_pkg::NUM_PLANES];
	logic               inside_link [fpct_pkg::NUM_PLANES];

	// chain accepts an item every cycle
	assign busy = 1'b0;

	// item entering the first cell
	always_comb begin
		tok_c[0].vld = start && !busy;
		tok_c[0].op  = operation;
		tok_c[0].idx = plane_index;
		tok_c[0].x   = vec_x;
		tok_c[0].y   = vec_y;
		tok_c[0].z   = vec_z;
		tok_c[0].w   = vec_w;
	end

	// cell chain
	for (genvar i = 0; i < fpct_pkg::NUM_PLANES; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign inside_link[i] = 1'b1;
		end else begin : g_rest
			assign inside_link[i] = vdt_c[i-1].in_all;
		end

		fpct_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.slot      (fpct_pkg::PIDX_W'(i)),
			.tok_in    (tok_c[i]),
			.tok_out   (tok_c[i+1]),
			.inside_in (inside_link[i]),
			.vdt_out   (vdt_c[i])
		);
	end

	// result straight from the last cell's verdict register
	assign done       = vdt_c[fpct_pkg::NUM_PLANES-1].vld;
	assign inside_res = vdt_c[fpct_pkg::NUM_PLANES-1].in_all;

	// a test gives its result after the fixed chain latency
	`FPCT_ASSERT_NOW(a_test_gives_result,
		start && !busy && (operation == fpct_pkg::OP_POINT || operation == fpct_pkg::OP_SPHERE),
		##(fpct_pkg::RES_LAT) done, "test item lost in cell chain")
	// a result always stems from a test accepted that many cycles earlier
	`FPCT_ASSERT_NOW(a_result_has_test, done,
		$past(start && !busy && (operation == fpct_pkg::OP_POINT ||
			operation == fpct_pkg::OP_SPHERE), fpct_pkg::RES_LAT),
		"result without a matching test item")
	// a load or unused code never raises the strobe
	`FPCT_ASSERT_NOW(a_load_no_result,
		start && !busy && (operation == fpct_pkg::OP_LOAD || operation == fpct_pkg::OP_UNUSED),
		##(fpct_pkg::RES_LAT) !done, "load item produced a result")

endmodule
